@@ hw/rtl/hts_pkg.sv @@
// Package for the hashed top-K selector: sizes, hash constants, opcodes,
// the command record passed from front end to back end, and FSM state types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hts_pkg;

    localparam int KEEP_DEPTH = 256;
    localparam int KEEP_AW    = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;
    localparam int FILL_W     = $clog2(KEEP_DEPTH + 1);

    localparam int OP_W    = 2;
    localparam int MASK_W  = 30;
    localparam int KEY_W   = 64;
    localparam int RANK_W  = 8;
    localparam int TALLY_W = 31;
    localparam int ENTRY_W = KEY_W + MASK_W;
    localparam int HALF_W  = KEY_W / 2;

    localparam logic [KEY_W-1:0]   MIX_C0     = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [KEY_W-1:0]   MIX_C1     = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [KEY_W-1:0]   MIX_C2     = 64'h94d0_49bb_1331_11eb;
    localparam logic [KEY_W-1:0]   SEED_RESET = 64'h4245_4228_4233_4245;
    localparam logic [TALLY_W-1:0] TALLY_MAX  = 31'h4000_0000;

    typedef enum logic [OP_W-1:0] {
        OP_OFFER = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [MASK_W-1:0] mask;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
    } t_cmd;

    typedef enum logic [2:0] {
        F_IDLE,
        F_M0,
        F_M1,
        F_M2,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CHK,
        B_SHIFT,
        B_PUT,
        B_RDOUT
    } t_bstate;

endpackage

`default_nettype wire

@@ hw/rtl/hashed_top_k_selector.sv @@
// Top level of the hashed top-K selector: front end, command queue, back end; uses hts_pkg.
// An offer into an empty store is written directly; otherwise entries shift until its slot
// is found, and on a full store the last entry is checked first and may reject the offer.
// A read past the kept count returns no entry. The front end stalls its input while it
// hashes an offer or passes a command on; the back end shifts one entry a cycle.
// Reset: seed to reset value, counts zero, store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module hashed_top_k_selector import hts_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [KEY_W-1:0]   i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [OP_W-1:0]    i_op,
    input  wire logic [MASK_W-1:0]  i_mask_in,
    input  wire logic [RANK_W-1:0]  i_rank,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_accepted,
    output logic [MASK_W-1:0]       o_entry_mask,
    output logic [KEY_W-1:0]        o_entry_key,
    output logic                    o_entry_valid,
    output logic [FILL_W-1:0]       o_kept_count,
    output logic [TALLY_W-1:0]      o_offered_count
);

    logic push, q_full, q_avail, q_pop;
    t_cmd front_cmd, q_cmd;

    hts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_op       (i_op),
        .i_mask_in  (i_mask_in),
        .i_rank     (i_rank),
        .o_push     (push),
        .i_q_full   (q_full),
        .o_cmd      (front_cmd)
    );

    hts_cmd_q u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .i_cmd   (front_cmd),
        .o_avail (q_avail),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    hts_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (q_avail),
        .o_pop           (q_pop),
        .i_cmd           (q_cmd),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_accepted      (o_accepted),
        .o_entry_mask    (o_entry_mask),
        .o_entry_key     (o_entry_key),
        .o_entry_valid   (o_entry_valid),
        .o_kept_count    (o_kept_count),
        .o_offered_count (o_offered_count)
    );

endmodule

`default_nettype wire

@@ hw/rtl/hts_front.sv @@
// Front end: takes transactions, holds the seed register and computes the
// splitmix64 key with one shared 32x32 multiplier. Depends on hts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hts_front import hts_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [KEY_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [MASK_W-1:0] i_mask_in,
    input  wire logic [RANK_W-1:0] i_rank,
    output logic                   o_push,
    input  wire logic              i_q_full,
    output t_cmd                   o_cmd
);

    t_fstate          r_state, n_state;
    logic             r_round, n_round;
    logic [KEY_W-1:0] r_seed;
    logic [KEY_W-1:0] r_x, n_x;
    logic [KEY_W-1:0] r_acc, n_acc;
    t_cmd             r_cmd, n_cmd;

    logic [HALF_W-1:0] mul_a, mul_b;
    logic [KEY_W-1:0]  prod;
    logic [KEY_W-1:0]  mix_c;
    logic [KEY_W-1:0]  acc_full;
    logic [KEY_W-1:0]  v0;

    assign mix_c    = r_round ? MIX_C2 : MIX_C1;
    assign mul_a    = (r_state == F_M2) ? r_x[KEY_W-1:HALF_W] : r_x[HALF_W-1:0];
    assign mul_b    = (r_state == F_M1) ? mix_c[KEY_W-1:HALF_W] : mix_c[HALF_W-1:0];
    assign prod     = mul_a * mul_b;
    assign acc_full = {r_acc[KEY_W-1:HALF_W] + prod[HALF_W-1:0], r_acc[HALF_W-1:0]};
    assign v0       = ({{(KEY_W-MASK_W){1'b0}}, i_mask_in} ^ r_seed) + MIX_C0;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_x     = r_x;
        n_acc   = r_acc;
        n_cmd   = r_cmd;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_cmd.op   = t_op'(i_op);
                    n_cmd.mask = i_mask_in;
                    n_cmd.rank = i_rank;
                    n_cmd.key  = '0;
                    if (t_op'(i_op) == OP_OFFER) begin
                        n_x     = v0 ^ (v0 >> 30);
                        n_round = 1'b0;
                        n_state = F_M0;
                    end else begin
                        n_state = F_PUSH;
                    end
                end
            end
            F_M0: begin
                n_acc   = prod;
                n_state = F_M1;
            end
            F_M1: begin
                n_acc   = acc_full;
                n_state = F_M2;
            end
            F_M2: begin
                if (!r_round) begin
                    n_x     = acc_full ^ (acc_full >> 27);
                    n_round = 1'b1;
                    n_state = F_M0;
                end else begin
                    n_cmd.key = acc_full ^ (acc_full >> 31);
                    n_state   = F_PUSH;
                end
            end
            F_PUSH: begin
                o_push = 1'b1;
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_round <= 1'b0;
            r_seed  <= SEED_RESET;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x   <= n_x;
        r_acc <= n_acc;
        r_cmd <= n_cmd;
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_cmd   = r_cmd;

endmodule

`default_nettype wire

@@ hw/rtl/hts_cmd_q.sv @@
// Two-entry command queue between front end and back end.
// Depends on hts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hts_cmd_q import hts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    output logic      o_full,
    input  wire t_cmd i_cmd,
    output logic      o_avail,
    input  wire logic i_pop,
    output t_cmd      o_cmd
);

    t_cmd       r_slot [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;
    assign o_cmd   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= !r_wr;
            end
            if (do_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/hts_back.sv @@
// Back end: sorted store in a one-write one-read memory, insertion by
// shifting one entry a cycle, rank reads, clear, and the result register.
// Depends on hts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hts_back import hts_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_avail,
    output logic                    o_pop,
    input  wire t_cmd               i_cmd,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_accepted,
    output logic [MASK_W-1:0]       o_entry_mask,
    output logic [KEY_W-1:0]        o_entry_key,
    output logic                    o_entry_valid,
    output logic [FILL_W-1:0]       o_kept_count,
    output logic [TALLY_W-1:0]      o_offered_count
);

    logic [ENTRY_W-1:0] r_store [KEEP_DEPTH];
    logic [ENTRY_W-1:0] r_rd;

    t_bstate             r_state, n_state;
    t_cmd                r_cmd, n_cmd;
    logic [KEEP_AW-1:0]  r_pos, n_pos;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [TALLY_W-1:0]  r_tally, n_tally;

    logic                r_out_valid, n_out_valid;
    logic                r_accepted, n_accepted;
    logic [MASK_W-1:0]   r_emask, n_emask;
    logic [KEY_W-1:0]    r_ekey, n_ekey;
    logic                r_evalid, n_evalid;

    logic                mem_we, mem_re;
    logic [KEEP_AW-1:0]  mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]  mem_wdata;
    logic [ENTRY_W-1:0]  new_ent;
    logic                new_less;

    assign new_ent  = {r_cmd.key, r_cmd.mask};
    assign new_less = (new_ent < r_rd);
    assign o_pop    = (r_state == B_IDLE) && i_avail && !r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_tally     = r_tally;
        n_out_valid = r_out_valid;
        n_accepted  = r_accepted;
        n_emask     = r_emask;
        n_ekey      = r_ekey;
        n_evalid    = r_evalid;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_pos;
        mem_raddr   = r_pos;
        mem_wdata   = new_ent;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    n_cmd      = i_cmd;
                    n_accepted = 1'b0;
                    n_emask    = '0;
                    n_ekey     = '0;
                    n_evalid   = 1'b0;
                    unique case (i_cmd.op)
                        OP_OFFER: begin
                            if (r_tally < TALLY_MAX) begin
                                n_tally = r_tally + 1'b1;
                            end
                            if (r_fill == '0) begin
                                mem_we      = 1'b1;
                                mem_waddr   = '0;
                                mem_wdata   = {i_cmd.key, i_cmd.mask};
                                n_fill      = r_fill + 1'b1;
                                n_accepted  = 1'b1;
                                n_out_valid = 1'b1;
                            end else if (r_fill < FILL_W'(KEEP_DEPTH)) begin
                                n_fill    = r_fill + 1'b1;
                                n_pos     = KEEP_AW'(r_fill);
                                mem_re    = 1'b1;
                                mem_raddr = KEEP_AW'(r_fill - 1'b1);
                                n_state   = B_SHIFT;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = KEEP_AW'(KEEP_DEPTH - 1);
                                n_state   = B_CHK;
                            end
                        end
                        OP_READ: begin
                            if (FILL_W'(i_cmd.rank) < r_fill) begin
                                mem_re    = 1'b1;
                                mem_raddr = KEEP_AW'(i_cmd.rank);
                                n_state   = B_RDOUT;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                        end
                        OP_CLEAR: begin
                            n_fill      = '0;
                            n_tally     = '0;
                            n_out_valid = 1'b1;
                        end
                        OP_NONE: begin
                            n_out_valid = 1'b1;
                        end
                        default: n_out_valid = 1'b1;
                    endcase
                end
            end
            B_CHK: begin
                if (new_less) begin
                    n_accepted = 1'b1;
                    n_pos      = KEEP_AW'(KEEP_DEPTH - 1);
                    if (KEEP_DEPTH == 1) begin
                        mem_we      = 1'b1;
                        mem_waddr   = '0;
                        n_out_valid = 1'b1;
                        n_state     = B_IDLE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = KEEP_AW'(KEEP_DEPTH - 2);
                        n_state   = B_SHIFT;
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            B_SHIFT: begin
                mem_we = 1'b1;
                if (new_less) begin
                    mem_wdata = r_rd;
                    n_pos     = r_pos - 1'b1;
                    if (r_pos == KEEP_AW'(1)) begin
                        n_state = B_PUT;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = r_pos - KEEP_AW'(2);
                    end
                end else begin
                    n_accepted  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            B_PUT: begin
                mem_we      = 1'b1;
                n_accepted  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = B_IDLE;
            end
            B_RDOUT: begin
                n_ekey      = r_rd[ENTRY_W-1:MASK_W];
                n_emask     = r_rd[MASK_W-1:0];
                n_evalid    = 1'b1;
                n_out_valid = 1'b1;
                n_state     = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_fill      <= '0;
            r_tally     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_tally     <= n_tally;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_accepted <= n_accepted;
        r_emask    <= n_emask;
        r_ekey     <= n_ekey;
        r_evalid   <= n_evalid;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd <= r_store[mem_raddr];
        end
    end

    // counts only move while no result is pending
    assign o_valid         = r_out_valid;
    assign o_accepted      = r_accepted;
    assign o_entry_mask    = r_emask;
    assign o_entry_key     = r_ekey;
    assign o_entry_valid   = r_evalid;
    assign o_kept_count    = r_fill;
    assign o_offered_count = r_tally;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(KEEP_DEPTH))
        else $error("fill level beyond store depth");

    a_tally_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally <= TALLY_MAX)
        else $error("offer tally beyond saturation bound");

    a_idle_when_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == B_IDLE)
        else $error("back end busy while a result is pending");

    a_fill_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_out_valid) && r_out_valid |-> $stable(r_fill) && $stable(r_tally))
        else $error("counts changed under a pending result");

endmodule

`default_nettype wire
